### rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Types, widths and helpers shared by the quadratic root solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int CW   = 16;                 // coefficient width, Q8.8
	localparam int RW   = 32;                 // result width, Q16.16
	localparam int DW   = 2 * CW + 2;         // signed discriminant
	localparam int MAGW = 2 * CW + 1;         // |discriminant|
	localparam int RADW = ((MAGW + 16 + 1) / 2) * 2; // sqrt radicand, even
	localparam int SW   = RADW / 2;           // square root width
	localparam int NBW  = CW + 9;             // -b * 256, signed
	localparam int SUMW = (NBW > SW + 1 ? NBW : SW + 1) + 1; // nb +/- s, signed
	localparam int NMAGW = SUMW + 6;          // |(nb +/- s) * 128|
	localparam int EXTW = (NMAGW > RW ? NMAGW : RW) + 2; // signed quotient

	typedef enum logic [1:0] {
		KIND_TWO_REAL,
		KIND_REPEATED,
		KIND_COMPLEX,
		KIND_DEGENERATE
	} kind_t;

	typedef struct packed {
		logic signed [CW-1:0] coef_square;
		logic signed [CW-1:0] coef_linear;
		logic signed [CW-1:0] coef_constant;
	} req_t;

	typedef struct packed {
		kind_t                root_kind;
		logic signed [RW-1:0] root_one;
		logic signed [RW-1:0] root_two;
		logic signed [RW-1:0] imag_part;
		logic                 saturated;
	} rsp_t;

	typedef struct packed {
		kind_t                 kind;
		logic signed [NBW-1:0] nb;
		logic signed [CW-1:0]  a;
	} sq_side_t;

	typedef struct packed {
		kind_t kind;
		logic  neg1;
		logic  neg2;
	} dv_side_t;

	// {clipped, value}
	function automatic logic [RW:0] clip_f(input logic signed [EXTW-1:0] v);
		logic signed [EXTW-1:0] hi;
		logic signed [EXTW-1:0] lo;
		logic [RW:0]            r;
		hi = {{(EXTW-RW+1){1'b0}}, {(RW-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			r = {1'b1, hi[RW-1:0]};
		end else if (v < lo) begin
			r = {1'b1, lo[RW-1:0]};
		end else begin
			r = {1'b0, v[RW-1:0]};
		end
		return r;
	endfunction

endpackage

### rtl/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front
// Input register, products b*b and a*c, then discriminant and classification.
// ----------------------------------------------------------------------------
module qrs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  qrs_pkg::req_t     req,
	output logic              out_valid,
	output logic [qrs_pkg::RADW-1:0] rad,
	output qrs_pkg::sq_side_t out_side
);
	import qrs_pkg::*;

	logic                   v_s1, v_s2, v_s3;
	logic signed [CW-1:0]   a_s1, b_s1, c_s1;
	logic signed [CW-1:0]   a_s2, b_s2;
	logic signed [2*CW-1:0] bb_s2, ac_s2;
	logic [MAGW-1:0]        mag_s3;
	sq_side_t               side_s3;

	logic signed [DW-1:0]   disc;
	logic signed [DW-1:0]   disc_abs;
	kind_t                  kind;

	always_comb begin
		disc     = DW'(bb_s2) - (DW'(ac_s2) <<< 2);
		disc_abs = disc[DW-1] ? -disc : disc;
		if (a_s2 == '0) begin
			kind = KIND_DEGENERATE;
		end else if (disc == '0) begin
			kind = KIND_REPEATED;
		end else if (disc[DW-1]) begin
			kind = KIND_COMPLEX;
		end else begin
			kind = KIND_TWO_REAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1         <= req.coef_square;
			b_s1         <= req.coef_linear;
			c_s1         <= req.coef_constant;
			a_s2         <= a_s1;
			b_s2         <= b_s1;
			bb_s2        <= b_s1 * b_s1;
			ac_s2        <= a_s1 * c_s1;
			mag_s3       <= disc_abs[MAGW-1:0];
			side_s3.kind <= kind;
			side_s3.nb   <= -(NBW'(b_s2) <<< 8);
			side_s3.a    <= a_s2;
		end
	end

	assign out_valid = v_s3;
	// radicand is |disc| * 2^16
	assign rad       = {{(RADW-MAGW-16){1'b0}}, mag_s3, 16'b0};
	assign out_side  = side_s3;

endmodule

### rtl/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [qrs_pkg::RADW-1:0] rad,
	input  qrs_pkg::sq_side_t        in_side,
	output logic                     out_valid,
	output logic [qrs_pkg::SW-1:0]   root,
	output qrs_pkg::sq_side_t        out_side
);
	import qrs_pkg::*;

	logic            v_s    [0:SW];
	logic [RADW-1:0] rad_s  [0:SW];
	logic [SW-1:0]   rem_s  [0:SW];
	logic [SW-1:0]   root_s [0:SW];
	sq_side_t        side_s [0:SW];

	assign v_s[0]    = in_valid;
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < SW; k++) begin : g_stage
		logic [SW+1:0] rem_sh, trial, rem_nx;
		logic [SW-1:0] root_nx;

		always_comb begin
			rem_sh = {rem_s[k], rad_s[k][RADW-1 -: 2]};
			trial  = {root_s[k], 2'b01};
			if (rem_sh >= trial) begin
				rem_nx  = rem_sh - trial;
				root_nx = {root_s[k][SW-2:0], 1'b1};
			end else begin
				rem_nx  = rem_sh;
				root_nx = {root_s[k][SW-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= {rad_s[k][RADW-3:0], 2'b00};
				rem_s[k+1]  <= rem_nx[SW-1:0];
				root_s[k+1] <= root_nx;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[SW];
	assign root      = root_s[SW];
	assign out_side  = side_s[SW];

endmodule

### rtl/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider, three dividends over one shared divisor,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [qrs_pkg::NMAGW-1:0] dvd [3],
	input  logic [qrs_pkg::CW-1:0]    dvs,
	input  qrs_pkg::dv_side_t         in_side,
	output logic                      out_valid,
	output logic [qrs_pkg::NMAGW-1:0] quo [3],
	output qrs_pkg::dv_side_t         out_side
);
	import qrs_pkg::*;

	logic             v_s    [0:NMAGW];
	logic [NMAGW-1:0] dvd_s  [0:NMAGW][3];
	logic [CW-1:0]    rem_s  [0:NMAGW][3];
	logic [CW-1:0]    dvs_s  [0:NMAGW];
	dv_side_t         side_s [0:NMAGW];

	assign v_s[0]    = in_valid;
	assign dvs_s[0]  = dvs;
	assign side_s[0] = in_side;

	for (genvar j = 0; j < 3; j++) begin : g_init
		assign dvd_s[0][j] = dvd[j];
		assign rem_s[0][j] = '0;
		assign quo[j]      = dvd_s[NMAGW][j];
	end

	for (genvar k = 0; k < NMAGW; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvs_s[k+1]  <= dvs_s[k];
				side_s[k+1] <= side_s[k];
			end
		end

		for (genvar j = 0; j < 3; j++) begin : g_lane
			logic [CW:0]   rem_sh, rem_df;
			logic          qbit;
			logic [CW-1:0] rem_nx;

			always_comb begin
				rem_sh = {rem_s[k][j], dvd_s[k][j][NMAGW-1]};
				rem_df = rem_sh - {1'b0, dvs_s[k]};
				qbit   = (rem_sh >= {1'b0, dvs_s[k]});
				rem_nx = qbit ? rem_df[CW-1:0] : rem_sh[CW-1:0];
			end

			// quotient bits shift in behind the consumed dividend bits
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1][j] <= rem_nx;
					dvd_s[k+1][j] <= {dvd_s[k][j][NMAGW-2:0], qbit};
				end
			end
		end
	end

	assign out_valid = v_s[NMAGW];
	assign out_side  = side_s[NMAGW];

endmodule

### rtl/quadratic_root_solver.sv
// Pipeline: 3 front stages, 25 sqrt stages, 1 numerator stage, 33 divider
//   stages, 1 output stage, from request beat to response.
// Throughput: one equation per cycle; the whole pipeline holds when a finished
//   response is not taken.
// Reset: arst_n clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2 + b*x + c from Q8.8 coefficients to saturated Q16.16 results.
// ----------------------------------------------------------------------------
module quadratic_root_solver (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  qrs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output qrs_pkg::rsp_t rsp
);
	import qrs_pkg::*;

	logic            en;
	logic            fr_valid;
	logic [RADW-1:0] fr_rad;
	sq_side_t        fr_side;
	logic            sq_valid;
	logic [SW-1:0]   sq_root;
	sq_side_t        sq_side;

	logic                   v_sn;
	logic [NMAGW-1:0]       num_sn [3];
	logic [CW-1:0]          dvs_sn;
	dv_side_t               side_sn;

	logic                   dv_valid;
	logic [NMAGW-1:0]       dv_quo [3];
	dv_side_t               dv_side;

	logic                   v_q;
	rsp_t                   rsp_q;

	logic signed [SUMW-1:0]  sel, n1, n2;
	logic signed [NMAGW:0]   n1x, n2x;
	logic [SW-1:0]           im_root;
	logic signed [EXTW-1:0]  q1, q2, qi;
	logic [RW:0]             c1, c2, ci;

	assign en        = !v_q || rsp_ready;
	assign req_ready = en;

	qrs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req_valid),
		.req       (req),
		.out_valid (fr_valid),
		.rad       (fr_rad),
		.out_side  (fr_side)
	);

	qrs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.rad       (fr_rad),
		.in_side   (fr_side),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	// numerators: (nb +/- s) * 128 for the roots, s * 128 for the imaginary part
	always_comb begin
		sel     = (sq_side.kind == KIND_TWO_REAL) ? SUMW'(sq_root) : '0;
		n1      = SUMW'(sq_side.nb) + sel;
		n2      = SUMW'(sq_side.nb) - sel;
		n1x     = (NMAGW+1)'(n1) <<< 7;
		n2x     = (NMAGW+1)'(n2) <<< 7;
		im_root = (sq_side.kind == KIND_COMPLEX) ? sq_root : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn <= 1'b0;
		end else if (en) begin
			v_sn <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_sn[0]    <= n1x[NMAGW] ? NMAGW'(-n1x) : NMAGW'(n1x);
			num_sn[1]    <= n2x[NMAGW] ? NMAGW'(-n2x) : NMAGW'(n2x);
			num_sn[2]    <= NMAGW'({im_root, 7'b0});
			dvs_sn       <= sq_side.a[CW-1] ? CW'(-sq_side.a) : CW'(sq_side.a);
			side_sn.kind <= sq_side.kind;
			side_sn.neg1 <= n1x[NMAGW] ^ sq_side.a[CW-1];
			side_sn.neg2 <= n2x[NMAGW] ^ sq_side.a[CW-1];
		end
	end

	qrs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_sn),
		.dvd       (num_sn),
		.dvs       (dvs_sn),
		.in_side   (side_sn),
		.out_valid (dv_valid),
		.quo       (dv_quo),
		.out_side  (dv_side)
	);

	always_comb begin
		q1 = EXTW'(dv_quo[0]);
		q2 = EXTW'(dv_quo[1]);
		qi = EXTW'(dv_quo[2]);
		if (dv_side.neg1) begin
			q1 = -q1;
		end
		if (dv_side.neg2) begin
			q2 = -q2;
		end
		c1 = clip_f(q1);
		c2 = clip_f(q2);
		ci = clip_f(qi);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q.root_kind <= dv_side.kind;
			if (dv_side.kind == KIND_DEGENERATE) begin
				rsp_q.root_one  <= '0;
				rsp_q.root_two  <= '0;
				rsp_q.imag_part <= '0;
				rsp_q.saturated <= 1'b0;
			end else begin
				rsp_q.root_one  <= c1[RW-1:0];
				rsp_q.root_two  <= c2[RW-1:0];
				rsp_q.imag_part <= ci[RW-1:0];
				rsp_q.saturated <= c1[RW] | c2[RW] | ci[RW];
			end
		end
	end

	assign rsp_valid = v_q;
	assign rsp       = rsp_q;

endmodule

### verif/quadratic_root_solver_tb.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_tb
// Drives coefficient sets with random gaps and checks each response against
// an independent 64-bit model of the discriminant, square root and divisions.
// ----------------------------------------------------------------------------
module quadratic_root_solver_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import qrs_pkg::*;

	localparam int N_RANDOM = 1400;

	class root_scoreboard;
		rsp_t pending_roots[$];
		int   mismatches;

		static function automatic longint unsigned int_sqrt(longint unsigned x);
			longint unsigned res;
			longint unsigned bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > x) bitv >>= 2;
			while (bitv != 0) begin
				if (x >= res + bitv) begin
					x -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		static function automatic logic signed [RW-1:0] clamp(longint v, ref logic sat);
			longint hi;
			longint lo;
			hi = (64'sd1 <<< (RW-1)) - 1;
			lo = -hi - 1;
			if (v > hi) begin
				v = hi;
				sat = 1'b1;
			end
			if (v < lo) begin
				v = lo;
				sat = 1'b1;
			end
			return v[RW-1:0];
		endfunction

		function void note_equation(req_t q);
			longint a, b, c, d, nb, r1, r2, im;
			longint unsigned s;
			logic sat;
			rsp_t e;
			a = q.coef_square;
			b = q.coef_linear;
			c = q.coef_constant;
			sat = 1'b0;
			im = 0;
			if (a == 0) begin
				e = '0;
				e.root_kind = KIND_DEGENERATE;
				pending_roots.push_back(e);
				return;
			end
			d = b * b - 4 * a * c;
			nb = -b * 256;
			if (d > 0) begin
				e.root_kind = KIND_TWO_REAL;
				s = int_sqrt(longint'(d) << 16);
				r1 = ((nb + longint'(s)) * 128) / a;
				r2 = ((nb - longint'(s)) * 128) / a;
			end else if (d == 0) begin
				e.root_kind = KIND_REPEATED;
				r1 = (nb * 128) / a;
				r2 = r1;
			end else begin
				e.root_kind = KIND_COMPLEX;
				s = int_sqrt(longint'(-d) << 16);
				r1 = (nb * 128) / a;
				r2 = r1;
				im = (longint'(s) * 128) / (a < 0 ? -a : a);
			end
			e.root_one = clamp(r1, sat);
			e.root_two = clamp(r2, sat);
			e.imag_part = clamp(im, sat);
			e.saturated = sat;
			pending_roots.push_back(e);
		endfunction

		function void check_roots(rsp_t got);
			rsp_t e;
			if (pending_roots.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response beat: %p", got);
				return;
			end
			e = pending_roots.pop_front();
			if (got.root_kind !== e.root_kind || got.root_one !== e.root_one ||
					got.root_two !== e.root_two || got.imag_part !== e.imag_part ||
					got.saturated !== e.saturated) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p, got %p", e, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	bit   stim_done = 1'b0;
	root_scoreboard sb = new();

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	quadratic_root_solver dut (.*);

	// idle stretches off now and then so back-to-back beats occur
	function automatic int draw_gap();
		if ($urandom_range(0, 3) == 0) return 0;
		return $urandom_range(0, 16);
	endfunction

	function automatic logic [CW-1:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($signed($urandom_range(0, 64)) - 32);
			3: return 16'($signed($urandom_range(0, 2048)) - 1024);
			default: return 16'($urandom);
		endcase
	endfunction

	// valid drops only when an idle stretch follows
	task automatic send_equation(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{coef_square: a, coef_linear: b, coef_constant: c};
		do @(posedge clk); while (!req_ready);
		sb.note_equation(req);
	endtask

	// pick b so the discriminant is exactly zero: b = 2k, a = k, c = k
	task automatic send_repeated();
		int k;
		k = $urandom_range(1, 100);
		send_equation(16'(k), 16'(2 * k), 16'(k));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_equation(16'd0, 16'd5, 16'd7);
		send_equation(16'd0, 16'h8000, 16'h7fff);
		send_equation(16'd256, 16'hfd00, 16'd512);
		send_equation(16'd256, 16'd512, 16'd256);
		send_equation(16'd256, 16'd0, 16'd256);
		send_equation(16'h8000, 16'h8000, 16'h8000);
		send_equation(16'h7fff, 16'h7fff, 16'h7fff);
		send_equation(16'h8000, 16'h7fff, 16'h7fff);
		send_equation(16'd1, 16'h8000, 16'h8000);
		send_equation(16'hffff, 16'h7fff, 16'h7fff);
		send_equation(16'd1, 16'd0, 16'h7fff);
		send_equation(16'd1, 16'h7fff, 16'd0);
		send_equation(16'hffff, 16'd0, 16'hffff);
		send_equation(16'hffff, 16'hffff, 16'hffff);
		send_equation(16'h5555, 16'haaaa, 16'h5555);
		send_equation(16'haaaa, 16'h5555, 16'haaaa);
		send_repeated();
		for (int i = 0; i < N_RANDOM; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_repeated();
			else
				send_equation(rand_coef(), rand_coef(), rand_coef());
		end
		req_valid <= 1'b0;
		stim_done <= 1'b1;
	end

	// receiver: stall draw per response beat
	initial begin
		int gap;
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			sb.check_roots(rsp);
		end
	end

	initial begin
		wait (stim_done);
		while (sb.pending_roots.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_roots.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
